>>> design/sbfdf_pkg.sv
// Package for the block deframer with CRC check.
// Holds the phase type, sync and length constants, verdict codes and the
// byte-wide CRC-16-CCITT update. No dependencies.
package sbfdf_pkg;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_SYNC = 3'd1,
    PH_HEAD = 3'd2,
    PH_BODY = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_GOOD    = 2'd1,
    VERDICT_BAD_CRC = 2'd2,
    VERDICT_SHORT   = 2'd3
  } verdict_t;

  localparam logic [7:0]  SyncFirst    = 8'h24;  // '$'
  localparam logic [7:0]  SyncSecond   = 8'h40;  // '@'
  localparam logic [15:0] MinLength    = 16'd8;
  localparam logic [15:0] CrcFirstByte = 16'd4;
  localparam logic [15:0] CrcPoly      = 16'h1021;

  // Header byte positions
  localparam logic [15:0] PosCrcLo = 16'd2;
  localparam logic [15:0] PosCrcHi = 16'd3;
  localparam logic [15:0] PosLenLo = 16'd6;
  localparam logic [15:0] PosLenHi = 16'd7;

  // One byte of CRC-16-CCITT, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/sbf_block_deframer_crc_check.sv
// Block deframer with CRC check: takes one byte per cycle and returns it with
// frame markers and a verdict in the following cycle from the output register. The
// header parse and a byte-wide CRC-16-CCITT update are combinational, so a
// new byte is taken every cycle as long as the output register is empty or
// being drained; sustained rate is one byte per clock.
// Depends on sbfdf_pkg.
module sbf_block_deframer_crc_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       in_frame,
  output logic       frame_first,
  output logic       frame_last,
  output logic [1:0] verdict,
  output logic       dropped
);

  sbfdf_pkg::phase_t phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] sent_crc, sent_crc_next;
  logic [15:0] block_length, block_length_next;
  logic [15:0] running_crc, running_crc_next;

  logic       r_in_frame, r_first, r_last, r_dropped;
  logic [1:0] r_verdict;
  logic       finish;
  logic [15:0] len_new;
  logic       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign len_new  = {data_byte, block_length[7:0]};

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    sent_crc_next     = sent_crc;
    block_length_next = block_length;
    running_crc_next  = running_crc;
    r_in_frame = 1'b0;
    r_first    = 1'b0;
    r_last     = 1'b0;
    r_verdict  = sbfdf_pkg::VERDICT_NONE;
    r_dropped  = 1'b0;
    finish     = 1'b0;
    case (phase)
      sbfdf_pkg::PH_SYNC: begin
        r_in_frame = 1'b1;
        if (data_byte == sbfdf_pkg::SyncSecond) begin
          phase_next      = sbfdf_pkg::PH_HEAD;
          byte_count_next = 16'd2;
        end else begin
          // broken sync: abort here, hunt again from the next byte
          r_last          = 1'b1;
          phase_next      = sbfdf_pkg::PH_HUNT;
          byte_count_next = '0;
        end
      end
      sbfdf_pkg::PH_HEAD: begin
        r_in_frame      = 1'b1;
        byte_count_next = byte_count + 16'd1;
        if (byte_count == sbfdf_pkg::PosCrcLo) begin
          sent_crc_next = {sent_crc[15:8], data_byte};
        end else if (byte_count == sbfdf_pkg::PosCrcHi) begin
          sent_crc_next = {data_byte, sent_crc[7:0]};
        end else begin
          if (byte_count >= sbfdf_pkg::CrcFirstByte) begin
            running_crc_next = sbfdf_pkg::crc_byte(running_crc, data_byte);
          end
          if (byte_count == sbfdf_pkg::PosLenLo) begin
            block_length_next = {block_length[15:8], data_byte};
          end else if (byte_count >= sbfdf_pkg::PosLenHi) begin
            block_length_next = len_new;
            if (len_new < sbfdf_pkg::MinLength) begin
              r_last          = 1'b1;
              r_verdict       = sbfdf_pkg::VERDICT_SHORT;
              phase_next      = sbfdf_pkg::PH_HUNT;
              byte_count_next = '0;
            end else if (len_new == sbfdf_pkg::MinLength) begin
              finish = 1'b1;
            end else begin
              phase_next = sbfdf_pkg::PH_BODY;
            end
          end
        end
      end
      sbfdf_pkg::PH_BODY: begin
        r_in_frame       = 1'b1;
        byte_count_next  = byte_count + 16'd1;
        running_crc_next = sbfdf_pkg::crc_byte(running_crc, data_byte);
        if (({1'b0, byte_count} + 17'd1) >= {1'b0, block_length}) begin
          finish = 1'b1;
        end
      end
      default: begin
        if (data_byte == sbfdf_pkg::SyncFirst) begin
          r_in_frame        = 1'b1;
          r_first           = 1'b1;
          phase_next        = sbfdf_pkg::PH_SYNC;
          byte_count_next   = 16'd1;
          sent_crc_next     = '0;
          block_length_next = '0;
          running_crc_next  = '0;
        end else begin
          phase_next = sbfdf_pkg::PH_HUNT;
          r_dropped  = 1'b1;
        end
      end
    endcase
    if (finish) begin
      r_last          = 1'b1;
      r_verdict       = (running_crc_next == sent_crc_next) ? sbfdf_pkg::VERDICT_GOOD
                                                            : sbfdf_pkg::VERDICT_BAD_CRC;
      phase_next      = sbfdf_pkg::PH_HUNT;
      byte_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sbfdf_pkg::PH_HUNT;
      byte_count   <= '0;
      sent_crc     <= '0;
      block_length <= '0;
      running_crc  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        sent_crc     <= sent_crc_next;
        block_length <= block_length_next;
        running_crc  <= running_crc_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte    <= data_byte;
      in_frame    <= r_in_frame;
      frame_first <= r_first;
      frame_last  <= r_last;
      verdict     <= r_verdict;
      dropped     <= r_dropped;
    end
  end

endmodule

>>> design/sbfdf_checker.sv
// Port-level checker for the block deframer, bound to the top level.
// Depends on sbfdf_pkg for the sync byte and verdict codes.
module sbfdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       in_frame,
  input logic       frame_first,
  input logic       frame_last,
  input logic [1:0] verdict,
  input logic       dropped
);

  // a verdict only comes with the closing byte of a candidate
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict != sbfdf_pkg::VERDICT_NONE) |-> frame_last && in_frame)
    else $error("verdict without frame_last");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !in_frame && !frame_first && !frame_last)
    else $error("dropped byte carries frame markers");

  // a candidate opens only on the sync byte and never closes on it
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_first |-> in_frame && !frame_last
                                 && (out_byte == sbfdf_pkg::SyncFirst))
    else $error("bad frame_first");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_frame != dropped))
    else $error("byte neither framed nor dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(verdict))
    else $error("stalled result changed");

endmodule

bind sbf_block_deframer_crc_check sbfdf_checker u_sbfdf_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte(out_byte),
  .in_frame(in_frame),
  .frame_first(frame_first),
  .frame_last(frame_last),
  .verdict(verdict),
  .dropped(dropped)
);
